FILE: design/sqw_pkg.sv
`timescale 1ns / 1ps

package sqw_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_TICK    = 2'd1,
    OP_QUARTER = 2'd2,
    OP_HALF    = 2'd3
  } opcode_t;

  localparam logic [2:0] REG_DUTY_VOL = 3'd0;
  localparam logic [2:0] REG_SWEEP    = 3'd1;
  localparam logic [2:0] REG_PER_LO   = 3'd2;
  localparam logic [2:0] REG_PER_HI   = 3'd3;
  localparam logic [2:0] REG_ENABLE   = 3'd4;

  localparam int PERIOD_W = 11;
  localparam int TIMER_W  = 12;
  localparam int SAMPLE_W = 7;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'h008;

  // bit n set: sequencer step n outputs the positive level
  localparam logic [7:0] DUTY_HIGH [4] = '{8'h80, 8'hC0, 8'hF0, 8'h3F};

  localparam logic [7:0] LENGTH_TABLE [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  // target reaching 0x800 is bit 11 of the 12-bit sum
  function automatic logic period_ok(input logic [PERIOD_W-1:0] per,
                                     input logic [2:0] shift,
                                     input logic negate);
    logic [PERIOD_W:0] target;
    target = {1'b0, per} + {1'b0, per >> shift};
    return (per >= PERIOD_MIN) && (negate || !target[PERIOD_W]);
  endfunction

endpackage

FILE: design/sqw_if.sv
`timescale 1ns / 1ps

interface sqw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] reg_index;
  logic [7:0] write_data;

  modport source (output valid, output opcode, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input reg_index, input write_data,
                output ready);
endinterface

interface sqw_out_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] sample;
  logic              active;

  modport source (output valid, output sample, output active, input ready);
  modport sink (input valid, input sample, input active, output ready);
endinterface

FILE: design/square_wave_sound_channel.sv
`timescale 1ns / 1ps
// channel  | dir | payload                              | handshake
// item     | in  | opcode[1:0] reg_index[2:0] write_data | valid/ready
// result   | out | sample[6:0] signed, active            | valid/ready
//
// One transaction in, one result out in the following cycle; a new item every clock unless a held result is not taken.
// Throughput is set by the single state-update pass feeding the result register.
// rst (synchronous) restores the channel state and empties the result register.
// item.ready drops only while a held result is not taken.

module square_wave_sound_channel (
  input  logic            clk,
  input  logic            rst,
  sqw_in_if.sink          item,
  sqw_out_if.source       result
);

  localparam int PW = sqw_pkg::PERIOD_W;
  localparam int TW = sqw_pkg::TIMER_W;

  logic [3:0]    const_volume,    const_volume_next;
  logic          const_vol_mode,  const_vol_mode_next;
  logic          halt_loop,       halt_loop_next;
  logic [1:0]    duty_select,     duty_select_next;
  logic [2:0]    sweep_shift,     sweep_shift_next;
  logic          sweep_negate,    sweep_negate_next;
  logic [2:0]    sweep_period,    sweep_period_next;
  logic          sweep_enable,    sweep_enable_next;
  logic [PW-1:0] period,          period_next;
  logic [TW-1:0] timer_count,     timer_count_next;
  logic [2:0]    seq_pos,         seq_pos_next;
  logic [7:0]    length_count,    length_count_next;
  logic [3:0]    env_level,       env_level_next;
  logic [3:0]    env_divider,     env_divider_next;
  logic          env_restart,     env_restart_next;
  logic [2:0]    sweep_divider,   sweep_divider_next;
  logic          sweep_reload,    sweep_reload_next;
  logic          channel_enabled, channel_enabled_next;
  logic [3:0]    cur_volume,      cur_volume_next;

  logic signed [sqw_pkg::SAMPLE_W-1:0] cur_sample, cur_sample_next;
  logic          active_out, active_next;
  logic          out_valid;
  logic          accept;
  logic [PW-1:0] delta;
  logic [5:0]    mag;

  sqw_pkg::opcode_t op;

  assign op         = sqw_pkg::opcode_t'(item.opcode);
  assign item.ready = !out_valid || result.ready;
  assign accept     = item.valid && item.ready;
  assign delta      = period >> sweep_shift;

  always_comb begin
    const_volume_next    = const_volume;
    const_vol_mode_next  = const_vol_mode;
    halt_loop_next       = halt_loop;
    duty_select_next     = duty_select;
    sweep_shift_next     = sweep_shift;
    sweep_negate_next    = sweep_negate;
    sweep_period_next    = sweep_period;
    sweep_enable_next    = sweep_enable;
    period_next          = period;
    timer_count_next     = timer_count;
    seq_pos_next         = seq_pos;
    length_count_next    = length_count;
    env_level_next       = env_level;
    env_divider_next     = env_divider;
    env_restart_next     = env_restart;
    sweep_divider_next   = sweep_divider;
    sweep_reload_next    = sweep_reload;
    channel_enabled_next = channel_enabled;
    cur_volume_next      = cur_volume;

    unique case (op)
      sqw_pkg::OP_WRITE: begin
        unique case (item.reg_index)
          sqw_pkg::REG_DUTY_VOL: begin
            const_volume_next   = item.write_data[3:0];
            const_vol_mode_next = item.write_data[4];
            halt_loop_next      = item.write_data[5];
            duty_select_next    = item.write_data[7:6];
            cur_volume_next     = item.write_data[4] ? item.write_data[3:0] : env_level;
          end
          sqw_pkg::REG_SWEEP: begin
            sweep_shift_next  = item.write_data[2:0];
            sweep_negate_next = item.write_data[3];
            sweep_period_next = item.write_data[6:4];
            sweep_enable_next = item.write_data[7];
            sweep_reload_next = 1'b1;
          end
          sqw_pkg::REG_PER_LO: begin
            period_next = {period[PW-1:8], item.write_data};
          end
          sqw_pkg::REG_PER_HI: begin
            period_next = {item.write_data[2:0], period[7:0]};
            if (channel_enabled) begin
              length_count_next = sqw_pkg::LENGTH_TABLE[item.write_data[7:3]];
            end
            seq_pos_next     = 3'd0;
            env_restart_next = 1'b1;
          end
          sqw_pkg::REG_ENABLE: begin
            channel_enabled_next = (item.write_data != 8'd0);
            if (item.write_data == 8'd0) begin
              length_count_next = 8'd0;
            end
          end
          default: begin
          end
        endcase
      end
      sqw_pkg::OP_TICK: begin
        if (timer_count == '0) begin
          timer_count_next = {period, 1'b0};
          seq_pos_next     = seq_pos - 3'd1;
        end else begin
          timer_count_next = timer_count - TW'(1);
        end
      end
      sqw_pkg::OP_QUARTER: begin
        priority if (env_restart) begin
          env_restart_next = 1'b0;
          env_level_next   = 4'hF;
          env_divider_next = const_volume;
        end else if (env_divider == 4'd0) begin
          env_divider_next = const_volume;
          if (env_level != 4'd0) begin
            env_level_next = env_level - 4'd1;
          end else begin
            env_level_next = halt_loop ? 4'hF : 4'h0;
          end
        end else begin
          env_divider_next = env_divider - 4'd1;
        end
        cur_volume_next = const_vol_mode ? const_volume : env_level_next;
      end
      sqw_pkg::OP_HALF: begin
        if (sweep_divider == 3'd0) begin
          sweep_divider_next = sweep_period;
          if (sweep_enable && sweep_shift != 3'd0
              && sqw_pkg::period_ok(period, sweep_shift, sweep_negate)) begin
            if (sweep_negate) begin
              period_next = period - delta - PW'(1);
            end else begin
              period_next = period + delta;
            end
          end
        end else begin
          sweep_divider_next = sweep_divider - 3'd1;
        end
        if (sweep_reload) begin
          sweep_reload_next  = 1'b0;
          sweep_divider_next = sweep_period;
        end
        if (length_count != 8'd0 && !halt_loop) begin
          length_count_next = length_count - 8'd1;
        end
      end
      default: begin
      end
    endcase

    active_next = (length_count_next != 8'd0)
                  && sqw_pkg::period_ok(period_next, sweep_shift_next, sweep_negate_next);
    mag = {cur_volume_next, 2'b00};
    if (!active_next) begin
      cur_sample_next = '0;
    end else if (sqw_pkg::DUTY_HIGH[duty_select_next][seq_pos_next]) begin
      cur_sample_next = $signed({1'b0, mag});
    end else begin
      cur_sample_next = -$signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      const_volume    <= '0;
      const_vol_mode  <= 1'b0;
      halt_loop       <= 1'b0;
      duty_select     <= '0;
      sweep_shift     <= '0;
      sweep_negate    <= 1'b0;
      sweep_period    <= '0;
      sweep_enable    <= 1'b0;
      period          <= '0;
      timer_count     <= TW'(1);
      seq_pos         <= '0;
      length_count    <= '0;
      env_level       <= '0;
      env_divider     <= 4'd1;
      env_restart     <= 1'b0;
      sweep_divider   <= 3'd1;
      sweep_reload    <= 1'b0;
      channel_enabled <= 1'b0;
      cur_volume      <= '0;
      cur_sample      <= '0;
      active_out      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        const_volume    <= const_volume_next;
        const_vol_mode  <= const_vol_mode_next;
        halt_loop       <= halt_loop_next;
        duty_select     <= duty_select_next;
        sweep_shift     <= sweep_shift_next;
        sweep_negate    <= sweep_negate_next;
        sweep_period    <= sweep_period_next;
        sweep_enable    <= sweep_enable_next;
        period          <= period_next;
        timer_count     <= timer_count_next;
        seq_pos         <= seq_pos_next;
        length_count    <= length_count_next;
        env_level       <= env_level_next;
        env_divider     <= env_divider_next;
        env_restart     <= env_restart_next;
        sweep_divider   <= sweep_divider_next;
        sweep_reload    <= sweep_reload_next;
        channel_enabled <= channel_enabled_next;
        cur_volume      <= cur_volume_next;
        cur_sample      <= cur_sample_next;
        active_out      <= active_next;
        out_valid       <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid  = out_valid;
  assign result.sample = cur_sample;
  assign result.active = active_out;

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted transaction produced no result");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !item.ready)
    else $error("input taken while result stalled");

  a_active_matches_state: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.active == ((length_count != 8'd0)
      && sqw_pkg::period_ok(period, sweep_shift, sweep_negate))))
    else $error("active flag disagrees with channel state");

  a_muted_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.active) |-> (result.sample == '0))
    else $error("nonzero sample while inactive");
`endif

endmodule
